>>> rtl/sfs_pkg.sv
// Shared types and constants for the speed-to-FOV smoother.
// No dependencies; used by every module of the block.
package sfs_pkg;

  localparam int unsigned SpeedW = 16;
  localparam int unsigned FovW   = 16;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned OpW    = 18;
  localparam int unsigned ResW   = 24;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [IdxW-1:0] REG_FOV_ENABLE     = 3'd0;
  localparam logic [IdxW-1:0] REG_ALPHA_RISE     = 3'd1;
  localparam logic [IdxW-1:0] REG_ALPHA_FALL     = 3'd2;
  localparam logic [IdxW-1:0] REG_INV_SPEED_FULL = 3'd3;
  localparam logic [IdxW-1:0] REG_MIN_FOV        = 3'd4;
  localparam logic [IdxW-1:0] REG_MAX_FOV        = 3'd5;
  localparam logic [IdxW-1:0] REG_MAX_STEP       = 3'd6;

  localparam logic [AlphaW-1:0] ONE_Q16     = 17'h10000;
  localparam logic [OpW-1:0]    THREE_Q16   = 18'h30000;
  localparam logic [ResW-1:0]   RND_HALF8   = 24'd128;
  localparam logic [ResW-1:0]   RND_HALF16  = 24'd32768;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic              snap;
  } in_item_t;

  typedef struct packed {
    logic [FovW-1:0]   fov_out;
    logic [SpeedW-1:0] smoothed_speed;
  } out_item_t;

  typedef struct packed {
    logic              fov_enable;
    logic [AlphaW-1:0] alpha_rise;
    logic [AlphaW-1:0] alpha_fall;
    logic [15:0]       inv_speed_full;
    logic [FovW-1:0]   min_fov;
    logic [FovW-1:0]   max_fov;
    logic [FovW-1:0]   max_step;
  } cfg_t;

  // One request to the shared multiplier: (op_a * op_b + half) >> (8 or 16)
  typedef struct packed {
    logic [OpW-1:0] op_a;
    logic [OpW-1:0] op_b;
    logic           shift8;
  } mul_req_t;

  function automatic logic [AlphaW-1:0] sat_q16(input logic [ResW-1:0] v);
    sat_q16 = (v > ResW'(ONE_Q16)) ? ONE_Q16 : v[AlphaW-1:0];
  endfunction

endpackage

>>> rtl/speed_to_fov_smoother_top.sv
// Speed-to-FOV smoother top: config registers, sequencer, output register.
// Each sample walks the sequencer through filter, normalize, smoothstep, span scale
// and slew on the shared multiplier; the first sample or a snap skips the filter pass,
// and with tracking disabled a primed block passes its held result to the output register.
// A new sample is taken only when the sequencer is idle; output stalls keep it busy.
// Reset: async active low; filter, FOV and primed flag clear, regs to defaults.
module speed_to_fov_smoother_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sfs_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sfs_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfs_pkg::AddrW-1:0]   paddr,
  input  logic [sfs_pkg::DataW-1:0]   pwdata,
  output logic [sfs_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  sfs_pkg::cfg_t      cfg;
  sfs_pkg::out_item_t res;
  sfs_pkg::out_item_t out_q;
  logic               out_valid_q, out_valid_d;
  logic               busy;
  logic               done;
  logic               out_free;

  sfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .busy_o     (busy),
    .out_free_i (out_free),
    .done_o     (done),
    .res_o      (res)
  );

  // output slot is free when empty or being taken this cycle
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = done || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/sfs_regs.sv
// APB-style configuration registers for the speed-to-FOV smoother.
// Depends on sfs_pkg for register indexes and the cfg_t bundle.
module sfs_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfs_pkg::AddrW-1:0]   paddr,
  input  logic [sfs_pkg::DataW-1:0]   pwdata,
  output logic [sfs_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output sfs_pkg::cfg_t               cfg_o
);

  sfs_pkg::cfg_t              cfg_q;
  logic [sfs_pkg::IdxW-1:0]   idx;
  logic                       wr_en;

  assign idx    = paddr[sfs_pkg::AddrW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fov_enable     <= 1'b1;
      cfg_q.alpha_rise     <= 17'd8192;
      cfg_q.alpha_fall     <= 17'd4096;
      cfg_q.inv_speed_full <= 16'd1638;
      cfg_q.min_fov        <= 16'd17920;
      cfg_q.max_fov        <= 16'd23040;
      cfg_q.max_step       <= 16'd256;
    end else if (wr_en) begin
      case (idx)
        sfs_pkg::REG_FOV_ENABLE:     cfg_q.fov_enable     <= pwdata[0];
        sfs_pkg::REG_ALPHA_RISE:     cfg_q.alpha_rise     <= pwdata[sfs_pkg::AlphaW-1:0];
        sfs_pkg::REG_ALPHA_FALL:     cfg_q.alpha_fall     <= pwdata[sfs_pkg::AlphaW-1:0];
        sfs_pkg::REG_INV_SPEED_FULL: cfg_q.inv_speed_full <= pwdata[15:0];
        sfs_pkg::REG_MIN_FOV:        cfg_q.min_fov        <= pwdata[15:0];
        sfs_pkg::REG_MAX_FOV:        cfg_q.max_fov        <= pwdata[15:0];
        sfs_pkg::REG_MAX_STEP:       cfg_q.max_step       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      sfs_pkg::REG_FOV_ENABLE:     prdata = 32'(cfg_q.fov_enable);
      sfs_pkg::REG_ALPHA_RISE:     prdata = 32'(cfg_q.alpha_rise);
      sfs_pkg::REG_ALPHA_FALL:     prdata = 32'(cfg_q.alpha_fall);
      sfs_pkg::REG_INV_SPEED_FULL: prdata = 32'(cfg_q.inv_speed_full);
      sfs_pkg::REG_MIN_FOV:        prdata = 32'(cfg_q.min_fov);
      sfs_pkg::REG_MAX_FOV:        prdata = 32'(cfg_q.max_fov);
      sfs_pkg::REG_MAX_STEP:       prdata = 32'(cfg_q.max_step);
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> rtl/sfs_mul.sv
// Shared rounding multiplier: registered (a * b + half) >> 8 or >> 16.
// Depends on sfs_pkg for mul_req_t and widths.
module sfs_mul (
  input  logic                       clk_i,
  input  sfs_pkg::mul_req_t          req_i,
  output logic [sfs_pkg::ResW-1:0]   res_o
);

  logic [2*sfs_pkg::OpW-1:0] prod;
  logic [2*sfs_pkg::OpW-1:0] sum;
  logic [sfs_pkg::ResW-1:0]  res_d;
  logic [sfs_pkg::ResW-1:0]  res_q;

  assign prod = req_i.op_a * req_i.op_b;

  always_comb begin
    if (req_i.shift8) begin
      sum   = prod + (2*sfs_pkg::OpW)'(sfs_pkg::RND_HALF8);
      res_d = sum[31:8];
    end else begin
      sum   = prod + (2*sfs_pkg::OpW)'(sfs_pkg::RND_HALF16);
      res_d = sfs_pkg::ResW'(sum[2*sfs_pkg::OpW-1:16]);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/sfs_seq.sv
// Sequencer and state of the speed-to-FOV smoother: filter, normalize,
// smoothstep, span scale and slew; every multiply goes through one shared multiplier.
// Depends on sfs_pkg and sfs_mul.
module sfs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfs_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  input  sfs_pkg::in_item_t in_data_i,
  output logic              busy_o,
  input  logic              out_free_i,
  output logic              done_o,
  output sfs_pkg::out_item_t res_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILT = 4'd1;
  localparam logic [3:0] S_FUPD = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_TSAT = 4'd4;
  localparam logic [3:0] S_SQR  = 4'd5;
  localparam logic [3:0] S_SMS  = 4'd6;
  localparam logic [3:0] S_SSAT = 4'd7;
  localparam logic [3:0] S_SPAN = 4'd8;
  localparam logic [3:0] S_TGT  = 4'd9;
  localparam logic [3:0] S_SLEW = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]                 state_q, state_d;
  logic [sfs_pkg::SpeedW-1:0] fil_q, fil_d;
  logic [sfs_pkg::FovW-1:0]   cur_q, cur_d;
  logic                       primed_q, primed_d;
  logic [sfs_pkg::SpeedW-1:0] spd_q, spd_d;
  logic                       jump_q, jump_d;
  logic [sfs_pkg::AlphaW-1:0] t_q, t_d;
  logic [sfs_pkg::FovW-1:0]   tgt_q, tgt_d;

  sfs_pkg::mul_req_t          mreq;
  logic [sfs_pkg::ResW-1:0]   mres;
  logic                       accept;
  logic                       rising;
  logic                       range_up;
  logic [sfs_pkg::SpeedW-1:0] diff;
  logic [sfs_pkg::AlphaW-1:0] alpha;
  logic [sfs_pkg::FovW-1:0]   span;
  logic [sfs_pkg::FovW-1:0]   step;

  sfs_mul u_mul (
    .clk_i (clk_i),
    .req_i (mreq),
    .res_o (mres)
  );

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign busy_o   = (state_q != S_IDLE);
  assign rising   = (spd_q >= fil_q);
  assign diff     = rising ? (spd_q - fil_q) : (fil_q - spd_q);
  assign alpha    = rising ? cfg_i.alpha_rise : cfg_i.alpha_fall;
  assign range_up = (cfg_i.max_fov >= cfg_i.min_fov);
  assign span     = range_up ? (cfg_i.max_fov - cfg_i.min_fov)
                             : (cfg_i.min_fov - cfg_i.max_fov);
  assign done_o   = (state_q == S_DONE) && out_free_i;
  assign res_o.fov_out        = cur_q;
  assign res_o.smoothed_speed = fil_q;

  // operand select for the shared multiplier
  always_comb begin
    mreq.op_a   = {2'b00, diff};
    mreq.op_b   = {1'b0, sfs_pkg::sat_q16(sfs_pkg::ResW'(alpha))};
    mreq.shift8 = 1'b0;
    case (state_q)
      S_NORM: begin
        mreq.op_a   = {2'b00, fil_q};
        mreq.op_b   = {2'b00, cfg_i.inv_speed_full};
        mreq.shift8 = 1'b1;
      end
      S_SQR: begin
        mreq.op_a = {1'b0, t_q};
        mreq.op_b = {1'b0, t_q};
      end
      S_SMS: begin
        mreq.op_a = {1'b0, mres[sfs_pkg::AlphaW-1:0]};
        mreq.op_b = sfs_pkg::THREE_Q16 - {t_q, 1'b0};
      end
      S_SPAN: begin
        mreq.op_a = {2'b00, span};
        mreq.op_b = {1'b0, t_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    fil_d    = fil_q;
    cur_d    = cur_q;
    primed_d = primed_q;
    spd_d    = spd_q;
    jump_d   = jump_q;
    t_d      = t_q;
    tgt_d    = tgt_q;
    step     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          spd_d = in_data_i.speed;
          if (!primed_q) begin
            fil_d   = in_data_i.speed;
            jump_d  = 1'b1;
            state_d = S_NORM;
          end else if (!cfg_i.fov_enable) begin
            state_d = S_DONE;
          end else if (in_data_i.snap) begin
            jump_d  = 1'b1;
            state_d = S_NORM;
          end else begin
            jump_d  = 1'b0;
            state_d = S_FILT;
          end
        end
      end
      S_FILT: state_d = S_FUPD;
      S_FUPD: begin
        fil_d   = rising ? (fil_q + mres[15:0]) : (fil_q - mres[15:0]);
        state_d = S_NORM;
      end
      S_NORM: state_d = S_TSAT;
      S_TSAT: begin
        t_d     = sfs_pkg::sat_q16(mres);
        state_d = S_SQR;
      end
      S_SQR:  state_d = S_SMS;
      S_SMS:  state_d = S_SSAT;
      S_SSAT: begin
        t_d     = sfs_pkg::sat_q16(mres);
        state_d = S_SPAN;
      end
      S_SPAN: state_d = S_TGT;
      S_TGT: begin
        tgt_d   = range_up ? (cfg_i.min_fov + mres[15:0]) : (cfg_i.min_fov - mres[15:0]);
        state_d = S_SLEW;
      end
      S_SLEW: begin
        primed_d = 1'b1;
        if (jump_q) begin
          cur_d = tgt_q;
        end else if (tgt_q >= cur_q) begin
          step  = tgt_q - cur_q;
          cur_d = cur_q + ((step > cfg_i.max_step) ? cfg_i.max_step : step);
        end else begin
          step  = cur_q - tgt_q;
          cur_d = cur_q - ((step > cfg_i.max_step) ? cfg_i.max_step : step);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fil_q    <= '0;
      cur_q    <= '0;
      primed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fil_q    <= fil_d;
      cur_q    <= cur_d;
      primed_q <= primed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spd_q  <= spd_d;
    jump_q <= jump_d;
    t_q    <= t_d;
    tgt_q  <= tgt_d;
  end

endmodule

>>> verif/speed_to_fov_smoother_tb.sv
// Self-checking testbench for speed_to_fov_smoother_top.
// Drives speed samples and APB register writes and predicts every FOV/speed result.
// Depends on rtl/sfs_pkg.sv and the block's RTL only.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SpeedW = sfs_pkg::SpeedW;
  localparam int unsigned FovW   = sfs_pkg::FovW;
  localparam int unsigned AlphaW = sfs_pkg::AlphaW;
  localparam int unsigned IdxW   = sfs_pkg::IdxW;
  localparam int unsigned AddrW  = sfs_pkg::AddrW;
  localparam int unsigned DataW  = sfs_pkg::DataW;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned NumSegments   = 8;
  localparam int unsigned SegmentItems  = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  sfs_pkg::in_item_t   in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  sfs_pkg::out_item_t  out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  // Shadow copy of the registers and the smoother state
  sfs_pkg::cfg_t       cfg_q;
  logic [SpeedW-1:0]   filt_q;
  logic [FovW-1:0]     fov_q;
  logic                primed_q;

  sfs_pkg::out_item_t  pending_fov[$];
  sfs_pkg::out_item_t  want;

  int unsigned       send_idle_pct;
  int unsigned       stall_pct;
  int unsigned       idle_cycles;
  int unsigned       n_sent;
  int unsigned       n_checked;
  int unsigned       n_settings;
  int unsigned       n_errors;

  speed_to_fov_smoother_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [FovW-1:0] fov_for_speed(logic [SpeedW-1:0] f);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] k;
    logic [63:0] s;
    logic [63:0] span;
    logic [63:0] part;
    t = (64'(f) * 64'(cfg_q.inv_speed_full) + 64'(sfs_pkg::RND_HALF8)) >> 8;
    if (t > 64'(sfs_pkg::ONE_Q16)) t = 64'(sfs_pkg::ONE_Q16);
    t2 = (t * t + 64'(sfs_pkg::RND_HALF16)) >> 16;
    k = 64'(sfs_pkg::THREE_Q16) - 2 * t;
    s = (t2 * k + 64'(sfs_pkg::RND_HALF16)) >> 16;
    if (s > 64'(sfs_pkg::ONE_Q16)) s = 64'(sfs_pkg::ONE_Q16);
    if (cfg_q.max_fov >= cfg_q.min_fov) begin
      span = 64'(cfg_q.max_fov - cfg_q.min_fov);
      part = (span * s + 64'(sfs_pkg::RND_HALF16)) >> 16;
      return cfg_q.min_fov + part[FovW-1:0];
    end
    span = 64'(cfg_q.min_fov - cfg_q.max_fov);
    part = (span * s + 64'(sfs_pkg::RND_HALF16)) >> 16;
    return cfg_q.min_fov - part[FovW-1:0];
  endfunction

  function automatic logic [SpeedW-1:0] filter_next(logic [SpeedW-1:0] spd,
                                                    logic [SpeedW-1:0] f);
    logic [AlphaW-1:0] a;
    logic [63:0]       adj;
    if (spd >= f) begin
      a = (cfg_q.alpha_rise > sfs_pkg::ONE_Q16) ? sfs_pkg::ONE_Q16 : cfg_q.alpha_rise;
      adj = (64'(spd - f) * 64'(a) + 64'(sfs_pkg::RND_HALF16)) >> 16;
      return f + adj[SpeedW-1:0];
    end
    a = (cfg_q.alpha_fall > sfs_pkg::ONE_Q16) ? sfs_pkg::ONE_Q16 : cfg_q.alpha_fall;
    adj = (64'(f - spd) * 64'(a) + 64'(sfs_pkg::RND_HALF16)) >> 16;
    return f - adj[SpeedW-1:0];
  endfunction

  function automatic logic [FovW-1:0] slew_fov(logic [FovW-1:0] cur, logic [FovW-1:0] tgt);
    logic [FovW-1:0] d;
    if (tgt >= cur) begin
      d = tgt - cur;
      if (d > cfg_q.max_step) d = cfg_q.max_step;
      return cur + d;
    end
    d = cur - tgt;
    if (d > cfg_q.max_step) d = cfg_q.max_step;
    return cur - d;
  endfunction

  task automatic advance_camera(sfs_pkg::in_item_t s);
    sfs_pkg::out_item_t r;
    if (!primed_q) begin
      filt_q   = s.speed;
      fov_q    = fov_for_speed(filt_q);
      primed_q = 1'b1;
    end else if (cfg_q.fov_enable) begin
      if (s.snap) begin
        fov_q = fov_for_speed(filt_q);
      end else begin
        filt_q = filter_next(s.speed, filt_q);
        fov_q  = slew_fov(fov_q, fov_for_speed(filt_q));
      end
    end
    r.fov_out        = fov_q;
    r.smoothed_speed = filt_q;
    pending_fov.push_back(r);
  endtask

  function automatic logic [DataW-1:0] shadow_reg(logic [IdxW-1:0] idx);
    case (idx)
      sfs_pkg::REG_FOV_ENABLE:     return DataW'(cfg_q.fov_enable);
      sfs_pkg::REG_ALPHA_RISE:     return DataW'(cfg_q.alpha_rise);
      sfs_pkg::REG_ALPHA_FALL:     return DataW'(cfg_q.alpha_fall);
      sfs_pkg::REG_INV_SPEED_FULL: return DataW'(cfg_q.inv_speed_full);
      sfs_pkg::REG_MIN_FOV:        return DataW'(cfg_q.min_fov);
      sfs_pkg::REG_MAX_FOV:        return DataW'(cfg_q.max_fov);
      sfs_pkg::REG_MAX_STEP:       return DataW'(cfg_q.max_step);
      default:                     return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers
  // Every task is entered and left just after a falling edge.

  task automatic send_sample(logic [SpeedW-1:0] spd, logic snap);
    sfs_pkg::in_item_t item;
    item.speed = spd;
    item.snap  = snap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    advance_camera(item);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic settle_block();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_fov.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [IdxW-1:0] idx, logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr) begin
      case (idx)
        sfs_pkg::REG_FOV_ENABLE:     cfg_q.fov_enable     = wdata[0];
        sfs_pkg::REG_ALPHA_RISE:     cfg_q.alpha_rise     = wdata[AlphaW-1:0];
        sfs_pkg::REG_ALPHA_FALL:     cfg_q.alpha_fall     = wdata[AlphaW-1:0];
        sfs_pkg::REG_INV_SPEED_FULL: cfg_q.inv_speed_full = wdata[15:0];
        sfs_pkg::REG_MIN_FOV:        cfg_q.min_fov        = wdata[FovW-1:0];
        sfs_pkg::REG_MAX_FOV:        cfg_q.max_fov        = wdata[FovW-1:0];
        sfs_pkg::REG_MAX_STEP:       cfg_q.max_step       = wdata[FovW-1:0];
        default: ;
      endcase
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_regs();
    logic [DataW-1:0] rd;
    for (int i = 0; i <= int'(sfs_pkg::REG_MAX_STEP); i++) begin
      apb_access(1'b0, IdxW'(i), '0, rd);
      if (rd !== shadow_reg(IdxW'(i))) begin
        n_errors++;
        $display("%0t: reg %0d readback expected %0d got %0d", $time, i,
                 shadow_reg(IdxW'(i)), rd);
      end
    end
  endtask

  task automatic apply_settings(sfs_pkg::cfg_t c);
    logic [DataW-1:0] rd;
    settle_block();
    apb_access(1'b1, sfs_pkg::REG_FOV_ENABLE,     DataW'(c.fov_enable),     rd);
    apb_access(1'b1, sfs_pkg::REG_ALPHA_RISE,     DataW'(c.alpha_rise),     rd);
    apb_access(1'b1, sfs_pkg::REG_ALPHA_FALL,     DataW'(c.alpha_fall),     rd);
    apb_access(1'b1, sfs_pkg::REG_INV_SPEED_FULL, DataW'(c.inv_speed_full), rd);
    apb_access(1'b1, sfs_pkg::REG_MIN_FOV,        DataW'(c.min_fov),        rd);
    apb_access(1'b1, sfs_pkg::REG_MAX_FOV,        DataW'(c.max_fov),        rd);
    apb_access(1'b1, sfs_pkg::REG_MAX_STEP,       DataW'(c.max_step),       rd);
    check_regs();
    n_settings++;
  endtask

  // ---------------------------------------------------------------- random picks

  function automatic logic [AlphaW-1:0] pick_alpha();
    case ($urandom_range(9))
      0:       return '0;
      1:       return sfs_pkg::ONE_Q16;
      2:       return AlphaW'($urandom_range(65537, 131071));
      default: return AlphaW'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [FovW-1:0] pick_fov();
    case ($urandom_range(7))
      0:       return '0;
      1:       return FovW'(46080);
      default: return FovW'($urandom_range(46080));
    endcase
  endfunction

  function automatic sfs_pkg::cfg_t random_settings();
    sfs_pkg::cfg_t c;
    c.fov_enable = ($urandom_range(7) != 0);
    c.alpha_rise = pick_alpha();
    c.alpha_fall = pick_alpha();
    case ($urandom_range(7))
      0:       c.inv_speed_full = '0;
      1:       c.inv_speed_full = 16'hFFFF;
      2:       c.inv_speed_full = 16'($urandom_range(65535));
      default: c.inv_speed_full = 16'($urandom_range(200, 4000));
    endcase
    c.min_fov = pick_fov();
    c.max_fov = pick_fov();
    case ($urandom_range(7))
      0:       c.max_step = '0;
      1:       c.max_step = FovW'(46080);
      2:       c.max_step = FovW'($urandom_range(46080));
      default: c.max_step = FovW'($urandom_range(1, 600));
    endcase
    return c;
  endfunction

  // Drifting speeds half the time, with jumps and rail values mixed in
  function automatic logic [SpeedW-1:0] next_speed(logic [SpeedW-1:0] prev);
    int v;
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3, 4: return SpeedW'($urandom_range(65535));
      default: begin
        v = int'(prev) + int'($urandom_range(6000)) - 3000;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return SpeedW'(v);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_register_defaults();
    check_regs();
  endtask

  // First sample primes even with tracking off; later samples hold
  task automatic test_priming_while_disabled();
    sfs_pkg::cfg_t c;
    c = cfg_q;
    c.fov_enable = 1'b0;
    apply_settings(c);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h1234, 1'b0);
  endtask

  task automatic test_tracking_directed();
    sfs_pkg::cfg_t c;
    c = cfg_q;
    c.fov_enable = 1'b1;
    apply_settings(c);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
  endtask

  task automatic test_register_extremes();
    sfs_pkg::cfg_t c;
    // saturating coefficients, full reciprocal, inverted FOV range, huge step
    c.fov_enable     = 1'b1;
    c.alpha_rise     = 17'h1FFFF;
    c.alpha_fall     = 17'h1FFFF;
    c.inv_speed_full = 16'hFFFF;
    c.min_fov        = FovW'(46080);
    c.max_fov        = '0;
    c.max_step       = FovW'(46080);
    apply_settings(c);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h3039, 1'b1);
    // frozen filter, zero reciprocal, zero step
    c.alpha_rise     = '0;
    c.alpha_fall     = '0;
    c.inv_speed_full = '0;
    c.min_fov        = '0;
    c.max_fov        = FovW'(46080);
    c.max_step       = '0;
    apply_settings(c);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    // exact coefficient of one, flat range, single-LSB step
    c.alpha_rise     = sfs_pkg::ONE_Q16;
    c.alpha_fall     = sfs_pkg::ONE_Q16;
    c.inv_speed_full = 16'd1638;
    c.min_fov        = FovW'(20000);
    c.max_fov        = FovW'(20000);
    c.max_step       = FovW'(1);
    apply_settings(c);
    send_sample(16'h5A5A, 1'b0);
    send_sample(16'hA5A5, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [SpeedW-1:0] spd;
    spd = '0;
    for (int seg = 0; seg < NumSegments; seg++) begin
      send_idle_pct = 0;
      stall_pct     = 0;
      apply_settings(random_settings());
      case (seg % 4)
        1:       send_idle_pct = 62;
        2:       stall_pct     = 62;
        3: begin
          send_idle_pct = 36;
          stall_pct     = 36;
        end
        default: ;
      endcase
      for (int i = 0; i < SegmentItems; i++) begin
        if (seg == 3 && i == SegmentItems / 2) settle_block();
        spd = next_speed(spd);
        send_sample(spd, ($urandom_range(9) == 0));
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fov.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result fov_out=%0d smoothed_speed=%0d", $time,
                 out_data_o.fov_out, out_data_o.smoothed_speed);
      end else begin
        want = pending_fov.pop_front();
        n_checked++;
        if (out_data_o.fov_out !== want.fov_out) begin
          n_errors++;
          $display("%0t: fov_out expected %0d got %0d", $time, want.fov_out,
                   out_data_o.fov_out);
        end
        if (out_data_o.smoothed_speed !== want.smoothed_speed) begin
          n_errors++;
          $display("%0t: smoothed_speed expected %0d got %0d", $time,
                   want.smoothed_speed, out_data_o.smoothed_speed);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any transaction on either channel or the APB port resets it
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending_fov.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    idle_cycles   = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_settings    = 0;
    n_errors      = 0;
    cfg_q.fov_enable     = 1'b1;
    cfg_q.alpha_rise     = AlphaW'(8192);
    cfg_q.alpha_fall     = AlphaW'(4096);
    cfg_q.inv_speed_full = 16'd1638;
    cfg_q.min_fov        = FovW'(17920);
    cfg_q.max_fov        = FovW'(23040);
    cfg_q.max_step       = FovW'(256);
    filt_q   = '0;
    fov_q    = '0;
    primed_q = 1'b0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_register_defaults();
    test_priming_while_disabled();
    test_tracking_directed();
    test_register_extremes();
    test_random_traffic();

    settle_block();
    $display("Sent %0d speed samples under %0d register settings, %0d results compared.",
             n_sent, n_settings, n_checked);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sfs_pkg.sv
rtl/sfs_regs.sv
rtl/sfs_mul.sv
rtl/sfs_seq.sv
rtl/speed_to_fov_smoother_top.sv
verif/speed_to_fov_smoother_tb.sv
